// ===== sv/ucr_pkg.sv =====
package ucr_pkg;

    // Input beat: one command, frame, completion or read request.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  frame_seq;
        logic [63:0] frame_data;
        logic [1:0]  backend_outcome;
        logic [9:0]  read_index;
    } t_in;

    // Output beat: status taken after the item.
    typedef struct packed {
        logic [2:0]  phase_code;
        logic [7:0]  acked_seq;
        logic [7:0]  version_out;
        logic [2:0]  pending_request;
        logic [10:0] fill_count;
        logic [7:0]  read_byte;
        logic        restart_pulse;
    } t_out;

    // Opcodes.
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_DATA     = 3'd1;
    localparam logic [2:0] OP_END      = 3'd2;
    localparam logic [2:0] OP_ABORT    = 3'd3;
    localparam logic [2:0] OP_POLL     = 3'd4;
    localparam logic [2:0] OP_COMPLETE = 3'd5;
    localparam logic [2:0] OP_READ     = 3'd6;

    // Phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_READY = 3'd1;
    localparam logic [2:0] PH_BUSY  = 3'd2;
    localparam logic [2:0] PH_DONE  = 3'd3;
    localparam logic [2:0] PH_ERROR = 3'd4;

    // Back-end requests.
    localparam logic [2:0] RQ_NONE   = 3'd0;
    localparam logic [2:0] RQ_BEGIN  = 3'd1;
    localparam logic [2:0] RQ_FLUSH  = 3'd2;
    localparam logic [2:0] RQ_FINISH = 3'd3;
    localparam logic [2:0] RQ_ABORT  = 3'd4;

    // Completion outcomes.
    localparam logic [1:0] OC_OK         = 2'd0;
    localparam logic [1:0] OC_WRITE_FAIL = 2'd1;
    localparam logic [1:0] OC_FINAL_FAIL = 2'd2;

    // Reset value of the protocol version register.
    localparam logic [7:0] VERSION_RESET = 8'd1;

endpackage

// ===== sv/ucr_alu.sv =====
module ucr_alu import ucr_pkg::*; #(
    parameter int WW    = 11,
    parameter int LIMIT = 1024
) (
    input  logic [WW-1:0] i_a,
    input  logic [WW-1:0] i_b,
    output logic [WW:0]   o_sum,
    output logic          o_lt,
    output logic          o_fits
);

    // One adder and two compares, shared by every step of the sequencer.
    assign o_sum  = {1'b0, i_a} + {1'b0, i_b};
    assign o_lt   = (i_a < i_b);
    assign o_fits = (o_sum <= (WW+1)'(LIMIT));

endmodule

// ===== sv/ucr_store.sv =====
module ucr_store import ucr_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    // Byte-wide store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/update_chunk_receiver.sv =====
// Channel  Direction  Handshake                  Payload
// input    in         i_in_valid / o_in_ready    i_in  (t_in)
// output   out        o_out_valid / i_out_ready  o_out (t_out)
// config   in         i_cfg_we (no wait)         i_cfg_data (protocol version)
//
// A command, completion, poll or dropped frame holds the sequencer in the accept,
// execute and output states, and its result is registered in the output state.
// A stored data frame also passes through the write, bump and post states: the
// byte store has one write port, so the frame is written one byte per cycle.
// A buffer read below the fill length passes the compare and wait states for the
// registered store read; one at or past the fill length skips the wait state.
// Reset is synchronous and active low; the store is not cleared.
// A stalled result holds the sequencer; the next item is taken after it moves.
module update_chunk_receiver import ucr_pkg::*; #(
    parameter int CHUNK_BYTES = 1024,
    parameter int FRAME_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(CHUNK_BYTES);
    localparam int FW = $clog2(CHUNK_BYTES + 1);
    localparam int WW = (FW > 10) ? FW : 10;
    localparam int IW = $clog2(FRAME_BYTES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_BUMP  = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;
    localparam logic [2:0] S_RCMP  = 3'd5;
    localparam logic [2:0] S_RWAIT = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]    r_state, n_state;
    t_in           r_item;
    logic [7:0]    r_version;
    logic [2:0]    r_phase, n_phase;
    logic [2:0]    r_req, n_req;
    logic [7:0]    r_last_seq, n_last_seq;
    logic [FW-1:0] r_fill, n_fill;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_rbyte, n_rbyte;
    logic          r_restart, n_restart;
    logic          r_out_valid;
    t_out          r_out;

    logic [WW-1:0] alu_a, alu_b;
    logic [WW:0]   alu_sum;
    logic          alu_lt, alu_fits;
    logic          mem_we;
    logic [7:0]    mem_wdata, mem_rdata;
    logic          seq_match;
    logic          out_free;

    // Shared adder and compare.
    ucr_alu #(.WW(WW), .LIMIT(CHUNK_BYTES)) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_sum  (alu_sum),
        .o_lt   (alu_lt),
        .o_fits (alu_fits)
    );

    // Chunk store, addressed by the adder output or the read index.
    ucr_store #(.DEPTH(CHUNK_BYTES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (alu_sum[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (alu_a[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Operand selection for the shared unit.
    always_comb begin
        alu_a = WW'(r_fill);
        alu_b = WW'(FRAME_BYTES);
        unique case (r_state)
            S_WRITE: alu_b = WW'(r_idx);
            S_RCMP, S_RWAIT: begin
                alu_a = WW'(r_item.read_index);
                alu_b = WW'(r_fill);
            end
            default: alu_b = WW'(FRAME_BYTES);
        endcase
    end

    assign mem_we    = (r_state == S_WRITE);
    assign mem_wdata = r_item.frame_data[8*r_idx +: 8];
    assign seq_match = (r_item.frame_seq == (r_last_seq + 8'd1));
    assign out_free  = !r_out_valid || i_out_ready;

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_req      = r_req;
        n_last_seq = r_last_seq;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_rbyte    = r_rbyte;
        n_restart  = r_restart;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state   = S_EXEC;
                    n_rbyte   = 8'd0;
                    n_restart = 1'b0;
                    n_idx     = '0;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                unique case (r_item.opcode)
                    OP_START: begin
                        if (r_phase == PH_IDLE || r_phase == PH_ERROR || r_phase == PH_DONE) begin
                            n_phase = PH_BUSY;
                            n_req   = RQ_BEGIN;
                        end
                    end
                    OP_DATA: begin
                        if (r_phase == PH_READY) begin
                            if (seq_match && alu_fits) begin
                                n_state = S_WRITE;
                            end else if (!alu_fits) begin
                                n_phase = PH_BUSY;
                                n_req   = RQ_FLUSH;
                            end
                        end
                    end
                    OP_END: begin
                        if (r_phase == PH_READY) begin
                            n_phase = PH_BUSY;
                            n_req   = RQ_FINISH;
                        end
                    end
                    OP_ABORT: begin
                        if (r_phase != PH_IDLE) begin
                            n_phase = PH_BUSY;
                            n_req   = RQ_ABORT;
                        end
                    end
                    OP_COMPLETE: begin
                        n_req = RQ_NONE;
                        unique case (r_req)
                            RQ_NONE: n_req = RQ_NONE;
                            RQ_BEGIN: begin
                                if (r_item.backend_outcome == OC_OK) begin
                                    n_fill     = '0;
                                    n_last_seq = 8'd0;
                                    n_phase    = PH_READY;
                                end else begin
                                    n_phase = PH_ERROR;
                                end
                            end
                            RQ_FLUSH: begin
                                if (r_item.backend_outcome == OC_OK) begin
                                    n_fill  = '0;
                                    n_phase = PH_READY;
                                end else begin
                                    n_phase = PH_ERROR;
                                end
                            end
                            RQ_FINISH: begin
                                if (r_item.backend_outcome == OC_OK) begin
                                    n_fill    = '0;
                                    n_phase   = PH_DONE;
                                    n_restart = 1'b1;
                                end else if (r_item.backend_outcome == OC_FINAL_FAIL) begin
                                    n_fill  = '0;
                                    n_phase = PH_ERROR;
                                end else begin
                                    // Tail write failed or unused outcome code.
                                    n_phase = PH_ERROR;
                                end
                            end
                            default: begin
                                n_fill  = '0;
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                    OP_READ: n_state = S_RCMP;
                    default: n_state = S_OUT;
                endcase
            end
            S_WRITE: begin
                // One byte per cycle at fill + index.
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(FRAME_BYTES - 1)) begin
                    n_state = S_BUMP;
                end
            end
            S_BUMP: begin
                n_fill     = alu_sum[FW-1:0];
                n_last_seq = r_item.frame_seq;
                n_state    = S_POST;
            end
            S_POST: begin
                if (!alu_fits) begin
                    n_phase = PH_BUSY;
                    n_req   = RQ_FLUSH;
                end
                n_state = S_OUT;
            end
            S_RCMP: begin
                // The store read is issued here; only in-range reads are kept.
                n_state = alu_lt ? S_RWAIT : S_OUT;
            end
            S_RWAIT: begin
                n_rbyte = mem_rdata;
                n_state = S_OUT;
            end
            default: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_version   <= VERSION_RESET;
            r_phase     <= PH_IDLE;
            r_req       <= RQ_NONE;
            r_last_seq  <= 8'd0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_req      <= n_req;
            r_last_seq <= n_last_seq;
            r_fill     <= n_fill;
            if (i_cfg_we) begin
                r_version <= i_cfg_data;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_rbyte   <= n_rbyte;
        r_restart <= n_restart;
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in;
        end
        if (r_state == S_OUT && out_free) begin
            r_out.phase_code      <= r_phase;
            r_out.acked_seq       <= r_last_seq;
            r_out.version_out     <= r_version;
            r_out.pending_request <= r_req;
            r_out.fill_count      <= 11'(r_fill);
            r_out.read_byte       <= r_rbyte;
            r_out.restart_pulse   <= r_restart;
        end
    end

    // No beat is taken while reset is held.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A request is pending exactly while the phase is busy.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req != RQ_NONE) == (r_phase == PH_BUSY))
        else $error("request latch and busy phase disagree");

    // The fill length never passes the store size.
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_fill) <= WW'(CHUNK_BYTES))
        else $error("fill length beyond chunk store");

    // A restart is only reported together with the done phase.
    a_restart_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.restart_pulse) |-> (r_out.phase_code == PH_DONE))
        else $error("restart without done phase");

    // Store writes happen only while the receiver is ready for data.
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_phase == PH_READY && r_item.opcode == OP_DATA))
        else $error("store write outside a data frame");

endmodule
